// File: hw/rtl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types, constants and helper functions for the particle update pipe.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int WORD_W   = 32;
  localparam int RAMP_W   = 16;
  localparam int KIND_W   = 4;
  localparam int COLOUR_W = 8;
  localparam int FT_W     = 16;
  localparam int CT_W     = 31;
  localparam int PROD_W   = WORD_W + FT_W + 1;
  localparam int WIDE_W   = 36;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_TIME   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CURRENT_TIME = 1'd1;

  // ramp end points in Q4.12 (6.0 and 8.0)
  localparam logic [RAMP_W-1:0] FIRE_END  = 16'd24576;
  localparam logic [RAMP_W-1:0] EXPL_END  = 16'd32768;
  // -1.0 s in Q19.12
  localparam logic [WORD_W-1:0] DEATH_NOW = 32'hFFFF_F000;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATIC   = 4'd0,
    KIND_GRAV     = 4'd1,
    KIND_SLOWGRAV = 4'd2,
    KIND_FIRE     = 4'd3,
    KIND_EXPLODE  = 4'd4,
    KIND_EXPLODE2 = 4'd5,
    KIND_BLOB     = 4'd6,
    KIND_BLOB2    = 4'd7
  } kind_t;

  typedef logic signed [WORD_W-1:0] word_t;

  // one particle as it enters
  typedef struct packed {
    word_t [2:0]         pos;
    word_t [2:0]         vel;
    logic [RAMP_W-1:0]   ramp;
    logic [KIND_W-1:0]   kind;
    logic [COLOUR_W-1:0] colour;
    word_t               death;
  } item_t;

  // after the multiply stage
  typedef struct packed {
    word_t [2:0]              pos;
    word_t [2:0]              vel;
    logic [2:0][PROD_W-1:0]   prod;
    logic [RAMP_W-1:0]        ramp;
    logic [KIND_W-1:0]        kind;
    logic [COLOUR_W-1:0]      colour;
    word_t                    death;
    logic                     expired;
  } mul_t;

  // after the accumulate stage
  typedef struct packed {
    word_t [2:0]         pos;
    word_t [2:0]         vel;
    logic [RAMP_W-1:0]   ramp;
    logic [KIND_W-1:0]   kind;
    logic [COLOUR_W-1:0] colour;
    word_t               death;
    logic                expired;
  } acc_t;

  // finished result
  typedef struct packed {
    logic                alive;
    word_t [2:0]         pos;
    word_t [2:0]         vel;
    logic [RAMP_W-1:0]   ramp;
    word_t               death;
    logic [COLOUR_W-1:0] colour;
    logic                unknown;
  } res_t;

  // clamp a wide sum to the signed 32-bit range
  function automatic word_t sat32(input logic signed [WIDE_W-1:0] x);
    if (x > 36'sd2147483647)
      return 32'sh7FFF_FFFF;
    else if (x < -36'sd2147483648)
      return 32'sh8000_0000;
    else
      return x[WORD_W-1:0];
  endfunction

  function automatic logic [COLOUR_W-1:0] fire_colour(input logic [2:0] idx);
    case (idx)
      3'd0:    return 8'h6d;
      3'd1:    return 8'h6b;
      3'd2:    return 8'h06;
      3'd3:    return 8'h05;
      3'd4:    return 8'h04;
      3'd5:    return 8'h03;
      default: return 8'h6d;
    endcase
  endfunction

  function automatic logic [COLOUR_W-1:0] explode_colour(input logic [2:0] idx);
    case (idx)
      3'd0:    return 8'h6f;
      3'd1:    return 8'h6d;
      3'd2:    return 8'h6b;
      3'd3:    return 8'h69;
      3'd4:    return 8'h67;
      3'd5:    return 8'h65;
      3'd6:    return 8'h63;
      3'd7:    return 8'h61;
      default: return 8'h61;
    endcase
  endfunction

  function automatic logic [COLOUR_W-1:0] explode2_colour(input logic [2:0] idx);
    case (idx)
      3'd0:    return 8'h6f;
      3'd1:    return 8'h6e;
      3'd2:    return 8'h6d;
      3'd3:    return 8'h6c;
      3'd4:    return 8'h6b;
      3'd5:    return 8'h6a;
      3'd6:    return 8'h68;
      3'd7:    return 8'h66;
      default: return 8'h66;
    endcase
  endfunction

endpackage

// File: hw/rtl/ppu_mult_stage.sv
// ----------------------------------------------------------------------------
// ppu_mult_stage
// Stage 1: velocity times frame time, expiry test and ramp advance.
// ----------------------------------------------------------------------------
module ppu_mult_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ppu_pkg::FT_W-1:0] frame_time,
  input  logic [ppu_pkg::CT_W-1:0] current_time,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ppu_pkg::item_t           in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ppu_pkg::mul_t            out_item
);

  ppu_pkg::mul_t     item_next;
  logic [18:0]       ft5;
  logic [19:0]       ft15;
  logic [16:0]       ramp_inc;
  logic [16:0]       ramp_sum;

  assign in_ready = !out_valid || out_ready;

  // per-frame ramp steps: ft*5/16, ft*10/16, ft*15/16
  assign ft5  = {3'b0, frame_time} + {1'b0, frame_time, 2'b0};
  assign ft15 = {frame_time, 4'b0} - {4'b0, frame_time};

  always_comb begin
    case (ppu_pkg::kind_t'(in_item.kind))
      ppu_pkg::KIND_FIRE:     ramp_inc = {2'b0, ft5[18:4]};
      ppu_pkg::KIND_EXPLODE:  ramp_inc = {1'b0, ft5[18:3]};
      ppu_pkg::KIND_EXPLODE2: ramp_inc = {1'b0, ft15[19:4]};
      default:                ramp_inc = '0;
    endcase
  end

  assign ramp_sum = {1'b0, in_item.ramp} + ramp_inc;

  // products and bookkeeping
  always_comb begin
    item_next.pos    = in_item.pos;
    item_next.vel    = in_item.vel;
    item_next.kind   = in_item.kind;
    item_next.colour = in_item.colour;
    item_next.death  = in_item.death;
    item_next.ramp   = ramp_sum[16] ? '1 : ramp_sum[15:0];
    item_next.expired = $signed({in_item.death[31], in_item.death})
                        < $signed({2'b0, current_time});
    for (int i = 0; i < 3; i++) begin
      item_next.prod[i] = $signed(in_item.vel[i]) * $signed({1'b0, frame_time});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// File: hw/rtl/ppu_accum_stage.sv
// ----------------------------------------------------------------------------
// ppu_accum_stage
// Stage 2: position update, per-kind velocity growth or drag, ramp end and
// colour lookup.
// ----------------------------------------------------------------------------
module ppu_accum_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ppu_pkg::mul_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output ppu_pkg::acc_t out_item
);

  ppu_pkg::acc_t                       item_next;
  logic signed [ppu_pkg::WIDE_W-1:0]   step16 [3];
  logic signed [ppu_pkg::WIDE_W-1:0]   step14 [3];
  logic signed [ppu_pkg::WIDE_W-1:0]   dv     [3];
  logic                                ramp_end;
  logic [2:0]                          ramp_idx;

  assign in_ready = !out_valid || out_ready;
  assign ramp_idx = in_item.ramp[14:12];

  // floored shifts of the product, sign-extended
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step16[i] = {{3{in_item.prod[i][48]}}, in_item.prod[i][48:16]};
      step14[i] = {in_item.prod[i][48], in_item.prod[i][48:14]};
    end
  end

  // velocity change per kind
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (ppu_pkg::kind_t'(in_item.kind))
        ppu_pkg::KIND_EXPLODE,
        ppu_pkg::KIND_BLOB:     dv[i] = step14[i];
        ppu_pkg::KIND_EXPLODE2: dv[i] = -step16[i];
        ppu_pkg::KIND_BLOB2:    dv[i] = (i == 2) ? '0 : -step14[i];
        default:                dv[i] = '0;
      endcase
    end
  end

  // ramp end, colour, and saturated position and velocity update
  always_comb begin
    item_next.pos     = in_item.pos;
    item_next.vel     = in_item.vel;
    item_next.ramp    = in_item.ramp;
    item_next.kind    = in_item.kind;
    item_next.colour  = in_item.colour;
    item_next.death   = in_item.death;
    item_next.expired = in_item.expired;
    ramp_end          = 1'b0;
    case (ppu_pkg::kind_t'(in_item.kind))
      ppu_pkg::KIND_FIRE: begin
        ramp_end = in_item.ramp >= ppu_pkg::FIRE_END;
        if (!ramp_end) item_next.colour = ppu_pkg::fire_colour(ramp_idx);
      end
      ppu_pkg::KIND_EXPLODE: begin
        ramp_end = in_item.ramp >= ppu_pkg::EXPL_END;
        if (!ramp_end) item_next.colour = ppu_pkg::explode_colour(ramp_idx);
      end
      ppu_pkg::KIND_EXPLODE2: begin
        ramp_end = in_item.ramp >= ppu_pkg::EXPL_END;
        if (!ramp_end) item_next.colour = ppu_pkg::explode2_colour(ramp_idx);
      end
      default: ramp_end = 1'b0;
    endcase
    if (ramp_end) item_next.death = ppu_pkg::DEATH_NOW;
    for (int i = 0; i < 3; i++) begin
      item_next.pos[i] = ppu_pkg::sat32(
        {{4{in_item.pos[i][31]}}, in_item.pos[i]} + step16[i]);
      item_next.vel[i] = ppu_pkg::sat32(
        {{4{in_item.vel[i][31]}}, in_item.vel[i]} + dv[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// File: hw/rtl/ppu_out_stage.sv
// ----------------------------------------------------------------------------
// ppu_out_stage
// Stage 3: gravity on vel_z, unknown-kind flag and expiry clear; holds the
// output register.
// ----------------------------------------------------------------------------
module ppu_out_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ppu_pkg::FT_W-1:0] frame_time,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  ppu_pkg::acc_t            in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output ppu_pkg::res_t            out_item
);

  ppu_pkg::res_t                     item_next;
  logic [18:0]                       ft5;
  logic signed [ppu_pkg::WIDE_W-1:0] grav;
  logic signed [ppu_pkg::WIDE_W-1:0] gadj;
  logic                              unknown;

  assign in_ready = !out_valid || out_ready;

  // gravity step ft*5/2 in Q19.12
  assign ft5  = {3'b0, frame_time} + {1'b0, frame_time, 2'b0};
  assign grav = {18'b0, ft5[18:1]};

  always_comb begin
    unknown = 1'b0;
    case (ppu_pkg::kind_t'(in_item.kind))
      ppu_pkg::KIND_STATIC: gadj = '0;
      ppu_pkg::KIND_FIRE:   gadj = grav;
      ppu_pkg::KIND_GRAV,
      ppu_pkg::KIND_SLOWGRAV,
      ppu_pkg::KIND_EXPLODE,
      ppu_pkg::KIND_EXPLODE2,
      ppu_pkg::KIND_BLOB,
      ppu_pkg::KIND_BLOB2:  gadj = -grav;
      default: begin
        gadj    = '0;
        unknown = 1'b1;
      end
    endcase
  end

  // result assembly, all zero for an expired particle
  always_comb begin
    item_next.alive   = 1'b1;
    item_next.pos     = in_item.pos;
    item_next.vel     = in_item.vel;
    item_next.vel[2]  = ppu_pkg::sat32(
      {{4{in_item.vel[2][31]}}, in_item.vel[2]} + gadj);
    item_next.ramp    = in_item.ramp;
    item_next.death   = in_item.death;
    item_next.colour  = in_item.colour;
    item_next.unknown = unknown;
    if (in_item.expired) item_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// File: hw/rtl/particle_physics_update.sv
// ----------------------------------------------------------------------------
// particle_physics_update
// Per-frame particle update: Euler motion plus per-kind gravity, velocity
// growth or drag and colour ramps, in Q19.12 fixed point with saturation.
// ----------------------------------------------------------------------------
//
//  channel   direction  fields
//  s_*       in         particle record (tdata) and kind (tuser)
//  m_*       out        updated record (tdata), alive / unknown_kind (tuser)
//  cfg_*     in         frame_time (index 0), current_time (index 1)
//
// Three register stages (multiply, accumulate, output); one item per clock
// unless the output stalls. The 32x17 velocity multipliers set the first
// stage. A stage takes a new item when empty or when its successor takes its
// item, so stalls propagate back without loss. Reset (rst, synchronous)
// empties the pipe and clears both configuration registers.
//
module particle_physics_update (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, ramp_phase, colour_in, death_time
  input  logic [247:0]                   s_tdata,
  // kind
  input  logic [3:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // new_pos_x..z, new_vel_x..z, new_ramp_phase, new_death_time, colour_out
  output logic [247:0]                   m_tdata,
  // alive, unknown_kind
  output logic [1:0]                     m_tuser,
  input  logic                           cfg_we,
  input  logic [ppu_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ppu_pkg::CT_W-1:0]       cfg_data
);

  logic [ppu_pkg::FT_W-1:0] frame_time;
  logic [ppu_pkg::CT_W-1:0] current_time;
  ppu_pkg::item_t           in_item;
  ppu_pkg::mul_t            mul_item;
  ppu_pkg::acc_t            acc_item;
  ppu_pkg::res_t            res_item;
  logic                     mul_valid, mul_ready;
  logic                     acc_valid, acc_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time   <= '0;
      current_time <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ppu_pkg::REG_FRAME_TIME:   frame_time   <= cfg_data[ppu_pkg::FT_W-1:0];
        ppu_pkg::REG_CURRENT_TIME: current_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the input item
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_item.pos[i] = s_tdata[32*i +: 32];
      in_item.vel[i] = s_tdata[96 + 32*i +: 32];
    end
    in_item.ramp   = s_tdata[207:192];
    in_item.colour = s_tdata[215:208];
    in_item.death  = s_tdata[247:216];
    in_item.kind   = s_tuser;
  end

  ppu_mult_stage u_mult (
    .clk          (clk),
    .rst          (rst),
    .frame_time   (frame_time),
    .current_time (current_time),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_item      (in_item),
    .out_valid    (mul_valid),
    .out_ready    (mul_ready),
    .out_item     (mul_item)
  );

  ppu_accum_stage u_accum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_item   (mul_item),
    .out_valid (acc_valid),
    .out_ready (acc_ready),
    .out_item  (acc_item)
  );

  ppu_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .frame_time (frame_time),
    .in_valid   (acc_valid),
    .in_ready   (acc_ready),
    .in_item    (acc_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_item   (res_item)
  );

  // pack the result item
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_tdata[32*i +: 32]      = res_item.pos[i];
      m_tdata[96 + 32*i +: 32] = res_item.vel[i];
    end
    m_tdata[207:192] = res_item.ramp;
    m_tdata[239:208] = res_item.death;
    m_tdata[247:240] = res_item.colour;
    m_tuser          = {res_item.unknown, res_item.alive};
  end

endmodule

// File: verif/particle_update_checker.sv
// ----------------------------------------------------------------------------
// particle_update_checker
// Watches the particle, result and register ports of the update pipe, keeps
// its own copy of frame_time and current_time, predicts the updated particle
// for every accepted item and compares each result item field by field.
// ----------------------------------------------------------------------------
module particle_update_checker
  import ppu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, ramp_phase, colour_in, death_time
  input  logic [247:0]          s_tdata,
  // kind
  input  logic [3:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // new_pos_x..z, new_vel_x..z, new_ramp_phase, new_death_time, colour_out
  input  logic [247:0]          m_tdata,
  // alive, unknown_kind
  input  logic [1:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CT_W-1:0]       cfg_data,
  output int                    fail_count,
  output int                    pending
);

  // palette ramps, indexed by the integer part of the ramp phase
  localparam logic [COLOUR_W-1:0] FIRE_RAMP [6] = '{8'h6d, 8'h6b, 8'h06, 8'h05, 8'h04, 8'h03};
  localparam logic [COLOUR_W-1:0] EXPLODE_RAMP [8] =
    '{8'h6f, 8'h6d, 8'h6b, 8'h69, 8'h67, 8'h65, 8'h63, 8'h61};
  localparam logic [COLOUR_W-1:0] EXPLODE2_RAMP [8] =
    '{8'h6f, 8'h6e, 8'h6d, 8'h6c, 8'h6b, 8'h6a, 8'h68, 8'h66};

  logic [FT_W-1:0] frame_time;
  logic [CT_W-1:0] current_time;
  res_t            updated_q[$];

  // clamp to the signed 32-bit range
  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647)
      return 64'sd2147483647;
    if (x < -64'sd2147483648)
      return -64'sd2147483648;
    return x;
  endfunction

  // ramp sum, held at the top of Q4.12
  function automatic int ramp_sum(input int r, input longint t);
    longint s;
    s = longint'(r) + t;
    return (s > 65535) ? 65535 : int'(s);
  endfunction

  // particle state one frame later
  function automatic res_t step_particle(input logic [247:0] d, input logic [3:0] k);
    res_t   r;
    longint ft, grav, death, p;
    longint v [3];
    int     ramp;
    logic [COLOUR_W-1:0] colour;

    r      = '0;
    ft     = longint'(frame_time);
    grav   = (ft * 5) >>> 1;
    death  = longint'($signed(d[247:216]));
    ramp   = int'(d[207:192]);
    colour = d[215:208];
    if (death < longint'(current_time))
      return r;

    // Euler step on the old velocity
    for (int i = 0; i < 3; i++) begin
      p    = longint'($signed(d[32*i +: 32]));
      v[i] = longint'($signed(d[96 + 32*i +: 32]));
      r.pos[i] = word_t'(clamp32(p + ((v[i] * ft) >>> 16)));
    end

    case (k)
      KIND_STATIC: ;
      KIND_GRAV, KIND_SLOWGRAV: begin
        v[2] = clamp32(v[2] - grav);
      end
      KIND_FIRE: begin
        ramp = ramp_sum(ramp, (ft * 5) >>> 4);
        if (ramp >= int'(FIRE_END))
          death = longint'($signed(DEATH_NOW));
        else
          colour = FIRE_RAMP[ramp >> 12];
        v[2] = clamp32(v[2] + grav);
      end
      KIND_EXPLODE: begin
        ramp = ramp_sum(ramp, (ft * 10) >>> 4);
        if (ramp >= int'(EXPL_END))
          death = longint'($signed(DEATH_NOW));
        else
          colour = EXPLODE_RAMP[ramp >> 12];
        for (int i = 0; i < 3; i++)
          v[i] = clamp32(v[i] + ((v[i] * ft) >>> 14));
        v[2] = clamp32(v[2] - grav);
      end
      KIND_EXPLODE2: begin
        ramp = ramp_sum(ramp, (ft * 15) >>> 4);
        if (ramp >= int'(EXPL_END))
          death = longint'($signed(DEATH_NOW));
        else
          colour = EXPLODE2_RAMP[ramp >> 12];
        for (int i = 0; i < 3; i++)
          v[i] = clamp32(v[i] - ((v[i] * ft) >>> 16));
        v[2] = clamp32(v[2] - grav);
      end
      KIND_BLOB: begin
        for (int i = 0; i < 3; i++)
          v[i] = clamp32(v[i] + ((v[i] * ft) >>> 14));
        v[2] = clamp32(v[2] - grav);
      end
      KIND_BLOB2: begin
        for (int i = 0; i < 2; i++)
          v[i] = clamp32(v[i] - ((v[i] * ft) >>> 14));
        v[2] = clamp32(v[2] - grav);
      end
      default: r.unknown = 1'b1;
    endcase

    r.alive = 1'b1;
    for (int i = 0; i < 3; i++)
      r.vel[i] = word_t'(v[i]);
    r.ramp   = ramp[RAMP_W-1:0];
    r.death  = word_t'(death);
    r.colour = colour;
    return r;
  endfunction

  task automatic compare(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin : monitor
    res_t  want;
    string axis [3];
    axis = '{"x", "y", "z"};
    if (rst) begin
      frame_time   = '0;
      current_time = '0;
      updated_q.delete();
      fail_count   = 0;
    end else begin
      // result side first: a result never belongs to the item accepted now
      if (m_tvalid && m_tready) begin
        if (updated_q.size() == 0) begin
          $error("result item arrived with no particle pending");
          fail_count++;
        end else begin
          want = updated_q.pop_front();
          compare("alive", 32'(want.alive), 32'(m_tuser[0]));
          compare("unknown_kind", 32'(want.unknown), 32'(m_tuser[1]));
          for (int i = 0; i < 3; i++) begin
            compare({"new_pos_", axis[i]}, want.pos[i], m_tdata[32*i +: 32]);
            compare({"new_vel_", axis[i]}, want.vel[i], m_tdata[96 + 32*i +: 32]);
          end
          compare("new_ramp_phase", 32'(want.ramp), 32'(m_tdata[207:192]));
          compare("new_death_time", want.death, m_tdata[239:208]);
          compare("colour_out", 32'(want.colour), 32'(m_tdata[247:240]));
        end
      end
      if (s_tvalid && s_tready)
        updated_q.push_back(step_particle(s_tdata, s_tuser));
      // register writes take effect after this edge
      if (cfg_we) begin
        if (cfg_addr == REG_FRAME_TIME)
          frame_time = cfg_data[FT_W-1:0];
        else if (cfg_addr == REG_CURRENT_TIME)
          current_time = cfg_data;
      end
    end
    pending = updated_q.size();
  end

endmodule

// File: verif/tb_particle_physics_update.sv
// ----------------------------------------------------------------------------
// tb_particle_physics_update
// Drives particle records into the update pipe under several frame_time and
// current_time settings: a directed set of corner particles, then random
// particles with random idle bursts on both sides and one long output stall.
// Checking is done by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_particle_physics_update;
  import ppu_pkg::*;

  localparam int    HALF_PERIOD     = 10;
  localparam int    RESET_CYCLES    = 5;
  localparam int    CYCLE_LIMIT     = 400000;
  localparam int    HOLD_CYCLES     = 80;
  localparam int    PHASES          = 7;
  localparam int    ITEMS_PER_PHASE = 262;
  localparam int    DRAIN_CYCLES    = 6;
  localparam word_t MAX_W           = 32'sh7FFF_FFFF;
  localparam word_t MIN_W           = 32'sh8000_0000;
  localparam word_t TEN             = 32'sd40960;   // 10.0 in Q19.12

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [247:0]          s_tdata;
  logic [3:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [247:0]          m_tdata;
  logic [1:0]            m_tuser;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CT_W-1:0]       cfg_data;

  int              fail_count;
  int              pending;
  int              cycle_count;
  int              idle_pct;
  bit              hold_off_req;
  logic [CT_W-1:0] cur_time;

  particle_physics_update i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  particle_update_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("particle_physics_update regression: fail");
      $finish;
    end
  end

  // result side: idle bursts, plus one long hold-off on request
  initial begin : sink
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        gap = $urandom_range(1, 11);
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [247:0] pack_particle(input word_t px, py, pz, vx, vy, vz,
                                                 input logic [RAMP_W-1:0] ramp,
                                                 input logic [COLOUR_W-1:0] colour,
                                                 input word_t death);
    return {death, colour, ramp, vz, vy, vx, pz, py, px};
  endfunction

  // one particle item, with an optional idle burst ahead of it
  task automatic offer_particle(input logic [247:0] data, input logic [3:0] kind);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait for every pending result
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CT_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // upper bits of the frame_time write are noise that must be dropped
  task automatic set_config(input logic [FT_W-1:0] ft, input logic [CT_W-1:0] ct);
    write_reg(REG_FRAME_TIME, {15'($urandom()), ft});
    write_reg(REG_CURRENT_TIME, ct);
    cur_time = ct;
  endtask

  // mostly live, well-behaved particles, some expired, some unknown kinds
  task automatic random_particle(output logic [247:0] data, output logic [3:0] kind);
    word_t               p [3];
    word_t               v [3];
    word_t               death;
    logic [RAMP_W-1:0]   ramp;
    logic [COLOUR_W-1:0] colour;
    int                  sel;

    sel  = $urandom_range(0, 99);
    kind = (sel < 88) ? 4'($urandom_range(0, 7)) : 4'($urandom_range(8, 15));
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 3) == 0)
        p[i] = $urandom();
      else
        p[i] = word_t'($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
      if ($urandom_range(0, 3) == 0)
        v[i] = $urandom();
      else
        v[i] = word_t'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    end
    case ($urandom_range(0, 3))
      0:       ramp = 16'($urandom());
      1:       ramp = FIRE_END - 16'($urandom_range(0, 2000));
      2:       ramp = EXPL_END - 16'($urandom_range(0, 3000));
      default: ramp = 16'($urandom_range(0, 16'h5FFF));
    endcase
    colour = 8'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 8)
      death = word_t'({1'b1, 31'($urandom())});
    else if (sel < 15)
      death = (cur_time == 0) ? MIN_W : word_t'($urandom_range(cur_time - 1, 0));
    else if (sel < 20)
      death = word_t'({1'b0, cur_time});
    else
      death = word_t'($urandom_range(32'h7FFF_FFFF, {1'b0, cur_time}));
    data = pack_particle(p[0], p[1], p[2], v[0], v[1], v[2], ramp, colour, death);
  endtask

  initial begin : stimulus
    logic [247:0] data;
    logic [3:0]   kind;
    int           phase_idle [PHASES];

    phase_idle   = '{10, 0, 25, 4, 40, 15, 0};
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_data     = '0;
    idle_pct     = 0;
    hold_off_req = 1'b0;
    cur_time     = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners at the longest frame
    set_config(16'hFFFF, '0);
    idle_pct = 10;
    offer_particle(pack_particle(4096, 8192, 12288, TEN, -TEN, TEN, '0, 8'h20, MAX_W),
                   KIND_STATIC);
    offer_particle(pack_particle(4096, 8192, 12288, TEN, -TEN, TEN, '0, 8'h20, MAX_W),
                   KIND_GRAV);
    offer_particle(pack_particle(-4096, 0, 0, -TEN, TEN, -TEN, '0, 8'h21, MAX_W),
                   KIND_SLOWGRAV);
    offer_particle(pack_particle(0, 0, 0, TEN, TEN, TEN, '0, 8'h22, 100), KIND_FIRE);
    // fire ramp crosses its end this frame
    offer_particle(pack_particle(0, 0, 0, TEN, TEN, TEN, FIRE_END - 16'd1, 8'h23, 100),
                   KIND_FIRE);
    offer_particle(pack_particle(0, 0, 0, TEN, -TEN, TEN, '0, 8'h24, 100), KIND_EXPLODE);
    offer_particle(pack_particle(0, 0, 0, TEN, -TEN, TEN, EXPL_END - 16'd100, 8'h25, 100),
                   KIND_EXPLODE);
    // ramp sum overflows and saturates
    offer_particle(pack_particle(0, 0, 0, TEN, TEN, -TEN, 16'hFFFF, 8'h26, 100),
                   KIND_EXPLODE2);
    offer_particle(pack_particle(0, 0, 0, MAX_W, MIN_W, MAX_W, '0, 8'h27, 100), KIND_BLOB);
    offer_particle(pack_particle(0, 0, 0, MAX_W, MIN_W, MIN_W, '0, 8'h28, 100), KIND_BLOB2);
    offer_particle(pack_particle(0, 0, 0, MIN_W, MIN_W, MIN_W, 16'h1234, 8'h29, 100),
                   KIND_EXPLODE2);
    offer_particle(pack_particle(TEN, TEN, TEN, TEN, TEN, TEN, 16'h1234, 8'hFF, 100), 4'd8);
    offer_particle(pack_particle(MAX_W, MIN_W, 0, MAX_W, MIN_W, 0, 16'hFFFF, 8'h80, MAX_W),
                   4'd15);
    // position saturation both ways
    offer_particle(pack_particle(MAX_W, MAX_W, MAX_W, MAX_W, MAX_W, MAX_W, '0, '0, 0),
                   KIND_STATIC);
    offer_particle(pack_particle(MIN_W, MIN_W, MIN_W, MIN_W, MIN_W, MIN_W, '0, '0, 0),
                   KIND_STATIC);
    // expired particles, one of an unknown kind
    offer_particle(pack_particle(TEN, TEN, TEN, TEN, TEN, TEN, 16'h0100, 8'h11, -1),
                   KIND_FIRE);
    offer_particle(pack_particle(TEN, TEN, TEN, TEN, TEN, TEN, 16'h0100, 8'h11, MIN_W),
                   4'd9);
    // death equal to current time still lives
    offer_particle(pack_particle(TEN, TEN, TEN, TEN, TEN, TEN, '0, 8'h12, 0), KIND_GRAV);
    offer_particle(pack_particle(0, 0, 0, 0, 0, 0, 16'hFFFF, 8'h13, 0), KIND_FIRE);
    offer_particle(pack_particle(0, 0, 0, 0, 0, 0, '0, '0, 0), KIND_EXPLODE);
    drain();

    // zero frame at the latest time
    set_config('0, 31'h7FFF_FFFF);
    offer_particle(pack_particle(TEN, TEN, TEN, TEN, TEN, TEN, '0, 8'h14, MAX_W), KIND_BLOB);
    offer_particle(pack_particle(TEN, TEN, TEN, TEN, TEN, TEN, '0, 8'h14, MAX_W - 1),
                   KIND_BLOB);
    offer_particle(pack_particle(0, 0, 0, 0, 0, 0, FIRE_END, 8'h15, MAX_W), KIND_FIRE);
    offer_particle(pack_particle(0, 0, 0, 0, 0, 0, EXPL_END - 16'd1, 8'h16, MAX_W),
                   KIND_EXPLODE);
    drain();

    // random phases under changing settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_config(16'hFFFF, '0);
        1:       set_config('0, 31'h7FFF_FFFF);
        2:       set_config(16'($urandom()), 31'($urandom_range(0, 65535)));
        6:       set_config(16'($urandom_range(1, 4000)), 31'($urandom_range(0, 4096)));
        default: set_config(16'($urandom()), 31'($urandom()));
      endcase
      idle_pct = phase_idle[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long output stall while input keeps coming
        if (ph == 2 && n == 30)
          hold_off_req = 1'b1;
        random_particle(data, kind);
        offer_particle(data, kind);
      end
      drain();
    end

    if (fail_count == 0)
      $display("particle_physics_update regression: pass");
    else
      $display("particle_physics_update regression: fail");
    $finish;
  end

endmodule
